FILE: rtl/core/olad_pkg.sv
// Shared types and codes for the ordered list block.
`timescale 1ns / 1ps
package olad_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SHOW   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_LISTED   = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  localparam logic [1:0] RA_ZERO = 2'd0;
  localparam logic [1:0] RA_NEXT = 2'd1;
  localparam logic [1:0] RA_SKIP = 2'd2;

  localparam logic [1:0] PTR_HOLD = 2'd0;
  localparam logic [1:0] PTR_CLR  = 2'd1;
  localparam logic [1:0] PTR_INC  = 2'd2;

  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;
  localparam logic [1:0] CNT_CLR  = 2'd3;

  localparam logic [1:0] IS_ZERO  = 2'd0;
  localparam logic [1:0] IS_RDATA = 2'd1;
  localparam logic [1:0] IS_VALUE = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } request_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] item;
    logic               last;
  } result_t;

  typedef struct packed {
    logic       load;
    logic [1:0] raddr_sel;
    logic [1:0] ptr_op;
    logic [1:0] cnt_op;
    logic       wr_tail;
    logic       wr_shift;
    logic       emit;
    logic [2:0] emit_status;
    logic [1:0] emit_item;
    logic       emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       full;
    logic       match;
    logic       at_end;
  } dp_stat_t;

endpackage

FILE: rtl/core/olad_ctrl.sv
// Controller state machine sequencing insert, delete, show and clear.
`timescale 1ns / 1ps
module olad_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  olad_pkg::dp_stat_t stat,
  output olad_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SHIFT    = 3'd3;
  localparam logic [2:0] S_SHOW     = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.raddr_sel   = olad_pkg::RA_ZERO;
    cmd.ptr_op      = olad_pkg::PTR_HOLD;
    cmd.cnt_op      = olad_pkg::CNT_HOLD;
    cmd.emit_item   = olad_pkg::IS_ZERO;
    cmd.emit_status = olad_pkg::ST_INSERTED;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.ptr_op    = olad_pkg::PTR_CLR;
        cmd.raddr_sel = olad_pkg::RA_ZERO;
        cmd.emit_last = 1'b1;
        unique case (stat.op)
          olad_pkg::OP_INSERT: begin
            cmd.emit = 1'b1;
            if (stat.full) begin
              cmd.emit_status = olad_pkg::ST_FULL;
            end else begin
              cmd.wr_tail     = 1'b1;
              cmd.cnt_op      = olad_pkg::CNT_INC;
              cmd.emit_status = olad_pkg::ST_INSERTED;
            end
            state_next = S_IDLE;
          end
          olad_pkg::OP_CLEAR: begin
            cmd.emit        = 1'b1;
            cmd.cnt_op      = olad_pkg::CNT_CLR;
            cmd.emit_status = olad_pkg::ST_CLEARED;
            state_next      = S_IDLE;
          end
          default: begin
            if (stat.empty) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = olad_pkg::ST_EMPTY;
              state_next      = S_IDLE;
            end else if (stat.op == olad_pkg::OP_DELETE) begin
              state_next = S_SCAN;
            end else begin
              state_next = S_SHOW;
            end
          end
        endcase
      end
      S_SCAN: begin
        cmd.raddr_sel = olad_pkg::RA_NEXT;
        if (stat.match) begin
          state_next = S_SHIFT;
        end else if (stat.at_end) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = olad_pkg::ST_NOTFOUND;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.ptr_op = olad_pkg::PTR_INC;
        end
      end
      S_SHIFT: begin
        cmd.raddr_sel = olad_pkg::RA_SKIP;
        if (stat.at_end) begin
          cmd.cnt_op      = olad_pkg::CNT_DEC;
          cmd.emit        = 1'b1;
          cmd.emit_status = olad_pkg::ST_REMOVED;
          cmd.emit_item   = olad_pkg::IS_VALUE;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.wr_shift = 1'b1;
          cmd.ptr_op   = olad_pkg::PTR_INC;
        end
      end
      S_SHOW: begin
        cmd.raddr_sel   = olad_pkg::RA_NEXT;
        cmd.ptr_op      = olad_pkg::PTR_INC;
        cmd.emit        = 1'b1;
        cmd.emit_status = olad_pkg::ST_LISTED;
        cmd.emit_item   = olad_pkg::IS_RDATA;
        cmd.emit_last   = stat.at_end;
        if (stat.at_end) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/olad_dp.sv
// Datapath: entry memory, fill count, walk pointer and result register.
`timescale 1ns / 1ps
module olad_dp #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  olad_pkg::request_t request,
  input  olad_pkg::dp_cmd_t  cmd,
  output olad_pkg::dp_stat_t stat,
  output logic               done,
  output olad_pkg::result_t  result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic               wen;
  logic [AW-1:0]      ptr;
  logic [CW-1:0]      count;
  logic [1:0]         op;
  logic signed [31:0] value;

  always_comb begin
    case (cmd.raddr_sel)
      olad_pkg::RA_NEXT: raddr = ptr + AW'(1);
      olad_pkg::RA_SKIP: raddr = ptr + AW'(2);
      default:           raddr = '0;
    endcase
  end

  assign wen   = cmd.wr_tail | cmd.wr_shift;
  assign waddr = cmd.wr_tail ? count[AW-1:0] : ptr;
  assign wdata = cmd.wr_tail ? value : rdata;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= request.op;
      value <= request.value;
    end
    case (cmd.ptr_op)
      olad_pkg::PTR_CLR: ptr <= '0;
      olad_pkg::PTR_INC: ptr <= ptr + AW'(1);
      default:           ptr <= ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt_op)
        olad_pkg::CNT_INC: count <= count + CW'(1);
        olad_pkg::CNT_DEC: count <= count - CW'(1);
        olad_pkg::CNT_CLR: count <= '0;
        default:           count <= count;
      endcase
    end
  end

  assign stat.op     = op;
  assign stat.empty  = (count == '0);
  assign stat.full   = (count == CW'(CAPACITY));
  assign stat.match  = (rdata == value);
  assign stat.at_end = ((CW'(ptr) + CW'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.status <= cmd.emit_status;
      result.last   <= cmd.emit_last;
      case (cmd.emit_item)
        olad_pkg::IS_RDATA: result.item <= rdata;
        olad_pkg::IS_VALUE: result.item <= value;
        default:            result.item <= '0;
      endcase
    end
  end

endmodule

FILE: rtl/core/ordered_list_append_delete.sv
// Top level of the ordered list: controller joined to datapath.
// Insert, clear and empty cases give their single result.
// Show of n entries: n results, one entry a cycle, with no gap between them.
// Delete over n entries: a single result, removed or, when nothing matches, not found.
// A new transfer is taken at the edge that ends the last result.
// Synchronous reset empties the list; the receiver cannot stall results.
`timescale 1ns / 1ps
module ordered_list_append_delete #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  olad_pkg::request_t request,
  output logic               done,
  output olad_pkg::result_t  result
);

  olad_pkg::dp_cmd_t  cmd;
  olad_pkg::dp_stat_t stat;

  olad_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  olad_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

FILE: rtl/core/olad_chk.sv
// Port-level checker for the ordered list, with its bind.
`timescale 1ns / 1ps
module olad_chk (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input olad_pkg::result_t result
);

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after transfer");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    done && result.status != olad_pkg::ST_LISTED |-> result.last)
    else $error("single result without last");

  a_zero_item: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == olad_pkg::ST_INSERTED || result.status == olad_pkg::ST_FULL ||
             result.status == olad_pkg::ST_NOTFOUND || result.status == olad_pkg::ST_EMPTY ||
             result.status == olad_pkg::ST_CLEARED) |-> result.item == '0)
    else $error("item not zero");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    done && result.last |=> !done)
    else $error("result straight after last");

endmodule

bind ordered_list_append_delete olad_chk u_olad_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

FILE: tb/sv/tb.sv
// Self-checking testbench for the ordered list block: directed table, then random traffic.
`timescale 1ns / 1ps
module tb;

  localparam int CAPACITY = 16;
  localparam int PLAN_ROWS = 25;
  localparam int RANDOM_ITEMS = 192;
  localparam int CALM_FROM = 160;
  localparam int DRAIN_AT = 120;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
    logic [4:0]         times;
    logic               typed;
    olad_pkg::result_t  want;
  } step_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  olad_pkg::request_t request;
  logic               done;
  olad_pkg::result_t  result;

  logic signed [31:0] list_vals [CAPACITY];
  int                 list_len;
  olad_pkg::result_t  step_results [$];
  olad_pkg::result_t  due_results [$];
  olad_pkg::result_t  head_due;
  int                 fail_count;
  step_t              plan [PLAN_ROWS];

  ordered_list_append_delete #(.CAPACITY(CAPACITY)) DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void list_apply(input olad_pkg::request_t req);
    int hit;
    step_results.delete();
    case (req.op)
      olad_pkg::OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          step_results.push_back(olad_pkg::result_t'{olad_pkg::ST_FULL, 32'sd0, 1'b1});
        end else begin
          list_vals[list_len] = req.value;
          list_len++;
          step_results.push_back(olad_pkg::result_t'{olad_pkg::ST_INSERTED, 32'sd0, 1'b1});
        end
      end
      olad_pkg::OP_DELETE: begin
        hit = -1;
        for (int i = 0; i < list_len; i++)
          if (hit < 0 && list_vals[i] == req.value) hit = i;
        if (list_len == 0) begin
          step_results.push_back(olad_pkg::result_t'{olad_pkg::ST_EMPTY, 32'sd0, 1'b1});
        end else if (hit < 0) begin
          step_results.push_back(olad_pkg::result_t'{olad_pkg::ST_NOTFOUND, 32'sd0, 1'b1});
        end else begin
          for (int j = hit; j + 1 < list_len; j++) list_vals[j] = list_vals[j + 1];
          list_len--;
          step_results.push_back(olad_pkg::result_t'{olad_pkg::ST_REMOVED, req.value, 1'b1});
        end
      end
      olad_pkg::OP_SHOW: begin
        if (list_len == 0) begin
          step_results.push_back(olad_pkg::result_t'{olad_pkg::ST_EMPTY, 32'sd0, 1'b1});
        end else begin
          for (int i = 0; i < list_len; i++)
            step_results.push_back(olad_pkg::result_t'{olad_pkg::ST_LISTED, list_vals[i],
                                                       i + 1 == list_len});
        end
      end
      default: begin
        list_len = 0;
        step_results.push_back(olad_pkg::result_t'{olad_pkg::ST_CLEARED, 32'sd0, 1'b1});
      end
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) return $urandom;
    if (k < 8) return $urandom_range(0, 7);
    if (k == 8) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFFFFFF;
        1: return 32'sh80000000;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return -$signed($urandom_range(1, 8));
  endfunction

  task automatic send(input olad_pkg::request_t req, input logic typed,
                      input olad_pkg::result_t want);
    @(negedge clk);
    start   <= 1'b1;
    request <= req;
    while (busy) @(negedge clk);
    list_apply(req);
    if (typed) due_results.push_back(want);
    else foreach (step_results[i]) due_results.push_back(step_results[i]);
    @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: status %0d item %0d last %0b",
                   result.status, result.item, result.last);
      end else begin
        head_due = due_results.pop_front();
        if (result.status !== head_due.status || result.item !== head_due.item ||
            result.last !== head_due.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected status %0d item %0d last %0b, got %0d %0d %0b",
                     head_due.status, head_due.item, head_due.last,
                     result.status, result.item, result.last);
        end
      end
    end
  end

  initial begin
    olad_pkg::request_t req;
    int                 r;
    logic               filling;

    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    list_len   = 0;
    fail_count = 0;

    plan = '{
      '{olad_pkg::OP_SHOW,   32'sd0,        5'd1,  1'b1, '{olad_pkg::ST_EMPTY,    32'sd0, 1'b1}},
      '{olad_pkg::OP_DELETE, 32'sd5,        5'd1,  1'b1, '{olad_pkg::ST_EMPTY,    32'sd0, 1'b1}},
      '{olad_pkg::OP_CLEAR,  32'sd0,        5'd1,  1'b1, '{olad_pkg::ST_CLEARED,  32'sd0, 1'b1}},
      '{olad_pkg::OP_INSERT, 32'sh7FFFFFFF, 5'd1,  1'b1, '{olad_pkg::ST_INSERTED, 32'sd0, 1'b1}},
      '{olad_pkg::OP_INSERT, 32'sh80000000, 5'd1,  1'b1, '{olad_pkg::ST_INSERTED, 32'sd0, 1'b1}},
      '{olad_pkg::OP_INSERT, 32'sd0,        5'd1,  1'b1, '{olad_pkg::ST_INSERTED, 32'sd0, 1'b1}},
      '{olad_pkg::OP_INSERT, -32'sd1,       5'd1,  1'b1, '{olad_pkg::ST_INSERTED, 32'sd0, 1'b1}},
      '{olad_pkg::OP_SHOW,   32'sd0,        5'd1,  1'b0, '0},
      '{olad_pkg::OP_DELETE, 32'sd0,        5'd1,  1'b1, '{olad_pkg::ST_REMOVED,  32'sd0, 1'b1}},
      '{olad_pkg::OP_DELETE, 32'sd12345,    5'd1,  1'b1, '{olad_pkg::ST_NOTFOUND, 32'sd0, 1'b1}},
      '{olad_pkg::OP_DELETE, 32'sh80000000, 5'd1,  1'b1,
        '{olad_pkg::ST_REMOVED, 32'sh80000000, 1'b1}},
      '{olad_pkg::OP_INSERT, 32'sd7,        5'd1,  1'b1, '{olad_pkg::ST_INSERTED, 32'sd0, 1'b1}},
      '{olad_pkg::OP_INSERT, 32'sd9,        5'd1,  1'b1, '{olad_pkg::ST_INSERTED, 32'sd0, 1'b1}},
      '{olad_pkg::OP_INSERT, 32'sd7,        5'd1,  1'b1, '{olad_pkg::ST_INSERTED, 32'sd0, 1'b1}},
      '{olad_pkg::OP_DELETE, 32'sd7,        5'd1,  1'b1, '{olad_pkg::ST_REMOVED,  32'sd7, 1'b1}},
      '{olad_pkg::OP_SHOW,   32'sd0,        5'd1,  1'b0, '0},
      '{olad_pkg::OP_DELETE, 32'sd7,        5'd1,  1'b1, '{olad_pkg::ST_REMOVED,  32'sd7, 1'b1}},
      '{olad_pkg::OP_DELETE, 32'sh7FFFFFFF, 5'd1,  1'b1,
        '{olad_pkg::ST_REMOVED, 32'sh7FFFFFFF, 1'b1}},
      '{olad_pkg::OP_INSERT, 32'sd100,      5'd14, 1'b0, '0},
      '{olad_pkg::OP_INSERT, 32'sd55,       5'd1,  1'b1, '{olad_pkg::ST_FULL,     32'sd0, 1'b1}},
      '{olad_pkg::OP_SHOW,   32'sd0,        5'd1,  1'b0, '0},
      '{olad_pkg::OP_DELETE, 32'sd113,      5'd1,  1'b1,
        '{olad_pkg::ST_REMOVED, 32'sd113, 1'b1}},
      '{olad_pkg::OP_INSERT, -32'sd5,       5'd1,  1'b1, '{olad_pkg::ST_INSERTED, 32'sd0, 1'b1}},
      '{olad_pkg::OP_CLEAR,  32'sd0,        5'd1,  1'b1, '{olad_pkg::ST_CLEARED,  32'sd0, 1'b1}},
      '{olad_pkg::OP_SHOW,   32'sd0,        5'd1,  1'b1, '{olad_pkg::ST_EMPTY,    32'sd0, 1'b1}}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int s = 0; s < PLAN_ROWS; s++) begin
      for (int k = 0; k < plan[s].times; k++) begin
        req.op    = plan[s].op;
        req.value = plan[s].value + k;
        send(req, plan[s].typed, plan[s].want);
        if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 5));
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == DRAIN_AT) begin
        hold_off(1);
        while (due_results.size() != 0) @(posedge clk);
      end
      r       = $urandom_range(0, 99);
      filling = ((n / 30) % 2) == 0;
      if (r < 3) req.op = olad_pkg::OP_CLEAR;
      else if (r < 15) req.op = olad_pkg::OP_SHOW;
      else if (r < (filling ? 82 : 40)) req.op = olad_pkg::OP_INSERT;
      else req.op = olad_pkg::OP_DELETE;
      req.value = pick_value();
      if (req.op == olad_pkg::OP_DELETE && list_len != 0 && $urandom_range(0, 3) != 0)
        req.value = list_vals[$urandom_range(0, list_len - 1)];
      send(req, 1'b0, '0);
      if (n < CALM_FROM && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 5));
    end

    @(negedge clk);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_count == 0 && due_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
